/* rtl/rss_pkg.sv */
// shared widths and opcodes for the running sample statistics block
package rss_pkg;

   // fixed field widths of the request and response words
   localparam int SAMPLE_W    = 16;
   localparam int COUNT_OUT_W = 24;
   localparam int MEAN_W      = 16;
   localparam int RMS_W       = 16;

   // request opcodes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

endpackage

/* rtl/rss_req_if.sv */
// request channel: opcode and sample word
interface rss_req_if;
   import rss_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output opcode, output sample, input ready);
   modport sink   (input valid, input opcode, input sample, output ready);
endinterface

/* rtl/rss_rsp_if.sv */
// response channel: count, min, max, mean, rms and saturation flag
interface rss_rsp_if;
   import rss_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [COUNT_OUT_W-1:0]     sample_count;
   logic signed [SAMPLE_W-1:0] minimum;
   logic signed [SAMPLE_W-1:0] maximum;
   logic signed [MEAN_W-1:0]   mean;
   logic [RMS_W-1:0]           rms;
   logic                       count_full;

   modport source (output valid, output sample_count, output minimum, output maximum,
                   output mean, output rms, output count_full, input ready);
   modport sink   (input valid, input sample_count, input minimum, input maximum,
                   input mean, input rms, input count_full, output ready);
endinterface

/* rtl/running_sample_statistics_unit.sv */
// running min, max, mean and rms over a stream of signed samples
//
// One request word is taken at a time. A clear word empties the statistics and
// answers without any arithmetic. An add word is squared and accumulated; then
// a radix-2 restoring divider forms sum/count in SAMPLE_BITS + COUNT_BITS steps
// and square_sum/count in 2*SAMPLE_BITS - 2 + COUNT_BITS steps, and the same
// subtractor then runs the SAMPLE_BITS steps of the digit-by-digit square root.
// The finished word sits in an output register, so the next request is taken
// while it waits to be read. Once the count reaches 2^COUNT_BITS - 1 further
// samples are ignored and count_full reads 1 until the next clear.
module running_sample_statistics_unit #(
   parameter int COUNT_BITS  = 24,
   parameter int SAMPLE_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   rss_req_if.sink    req_if,
   rss_rsp_if.source  rsp_if
);
   import rss_pkg::*;

   localparam int S      = SAMPLE_BITS;
   localparam int C      = COUNT_BITS;
   localparam int SUM_W  = S + C;
   localparam int SQ_W   = 2 * S - 2 + C;
   localparam int UW     = (C + 1 > S + 2) ? C + 1 : S + 2;
   localparam int STEP_W = $clog2(SQ_W + 1);
   localparam logic [C-1:0] COUNT_MAX = {C{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_LOAD_MEAN,
      ST_DIV_MEAN,
      ST_LOAD_SQ,
      ST_DIV_SQ,
      ST_LOAD_ROOT,
      ST_ROOT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // running statistics
   logic signed [S-1:0]     min_ff, min_in;
   logic signed [S-1:0]     max_ff, max_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]         sqsum_ff, sqsum_in;
   logic [C-1:0]            count_ff, count_in;

   // working registers
   logic signed [S-1:0]     smp_ff, smp_in;
   logic [2*S-1:0]          sq_ff, sq_in;
   logic [SQ_W-1:0]         dvd_ff, dvd_in;
   logic [UW-1:0]           rem_ff, rem_in;
   logic [S-1:0]            root_ff, root_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [MEAN_W-1:0]       mean_ff, mean_in;

   // output word register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [SAMPLE_W-1:0]     rsp_min_ff, rsp_min_in;
   logic [SAMPLE_W-1:0]     rsp_max_ff, rsp_max_in;
   logic [MEAN_W-1:0]       rsp_mean_ff, rsp_mean_in;
   logic [RMS_W-1:0]        rsp_rms_ff, rsp_rms_in;
   logic                    rsp_full_ff, rsp_full_in;

   // shared subtractor: divider step or square root step
   logic [UW:0]             sub_a;
   logic [UW:0]             sub_b;
   logic [UW:0]             sub_diff;
   logic                    sub_fits;
   logic signed [2*S-1:0]   prod;
   logic [SUM_W-1:0]        sum_mag;
   logic [SUM_W:0]          quot_ext;
   logic [SUM_W:0]          mean_full;
   logic                    req_take;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;

   always_comb begin
      if (state_ff == ST_ROOT) begin
         sub_a = (UW + 1)'({rem_ff[S-1:0], dvd_ff[SQ_W-1 -: 2]});
         sub_b = (UW + 1)'({root_ff, 2'b01});
      end else begin
         sub_a = (UW + 1)'({rem_ff[C-1:0], dvd_ff[SQ_W-1]});
         sub_b = (UW + 1)'(count_ff);
      end
      sub_diff = sub_a - sub_b;
      sub_fits = !sub_diff[UW];
   end

   // square, magnitude and signed mean helpers
   always_comb begin
      prod      = smp_ff * smp_ff;
      sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      quot_ext  = {1'b0, dvd_ff[SUM_W-1:0]};
      mean_full = sum_ff[SUM_W-1] ? (~quot_ext + 1'b1) : quot_ext;
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      sqsum_in     = sqsum_ff;
      count_in     = count_ff;
      smp_in       = smp_ff;
      sq_in        = sq_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_rms_in   = rsp_rms_ff;
      rsp_full_in  = rsp_full_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_if.opcode == OP_CLEAR) begin
                  min_in   = '0;
                  max_in   = '0;
                  sum_in   = '0;
                  sqsum_in = '0;
                  count_in = '0;
                  state_in = ST_DONE;
               end else begin
                  smp_in   = $signed(req_if.sample[S-1:0]);
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            sq_in    = $unsigned(prod);
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (count_ff != COUNT_MAX) begin
               if (count_ff == '0) begin
                  min_in = smp_ff;
                  max_in = smp_ff;
               end else begin
                  if (smp_ff < min_ff) min_in = smp_ff;
                  if (smp_ff > max_ff) max_in = smp_ff;
               end
               sum_in   = sum_ff + SUM_W'(smp_ff);
               sqsum_in = sqsum_ff + SQ_W'(sq_ff);
               count_in = count_ff + 1'b1;
            end
            state_in = ST_LOAD_MEAN;
         end
         ST_LOAD_MEAN: begin
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               dvd_in   = SQ_W'(sum_mag) << (SQ_W - SUM_W);
               rem_in   = '0;
               step_in  = STEP_W'(SUM_W);
               state_in = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN, ST_DIV_SQ: begin
            rem_in  = sub_fits ? sub_diff[UW-1:0] : sub_a[UW-1:0];
            dvd_in  = {dvd_ff[SQ_W-2:0], sub_fits};
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = (state_ff == ST_DIV_MEAN) ? ST_LOAD_SQ : ST_LOAD_ROOT;
            end
         end
         ST_LOAD_SQ: begin
            mean_in  = mean_full[MEAN_W-1:0];
            dvd_in   = sqsum_ff;
            rem_in   = '0;
            step_in  = STEP_W'(SQ_W);
            state_in = ST_DIV_SQ;
         end
         ST_LOAD_ROOT: begin
            dvd_in   = SQ_W'(dvd_ff[2*S-1:0]) << (SQ_W - 2 * S);
            rem_in   = '0;
            root_in  = '0;
            step_in  = STEP_W'(S);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = sub_fits ? sub_diff[UW-1:0] : sub_a[UW-1:0];
            dvd_in  = {dvd_ff[SQ_W-3:0], 2'b00};
            root_in = {root_ff[S-2:0], sub_fits};
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // load the output word once the previous one is gone
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = COUNT_OUT_W'(count_ff);
               rsp_min_in   = SAMPLE_W'(min_ff);
               rsp_max_in   = SAMPLE_W'(max_ff);
               rsp_mean_in  = (count_ff == '0) ? '0 : mean_ff;
               rsp_rms_in   = (count_ff == '0) ? '0 : RMS_W'(root_ff);
               rsp_full_in  = (count_ff == COUNT_MAX);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         sqsum_ff     <= sqsum_in;
         count_ff     <= count_in;
      end
      smp_ff       <= smp_in;
      sq_ff        <= sq_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      step_ff      <= step_in;
      mean_ff      <= mean_in;
      rsp_count_ff <= rsp_count_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_rms_ff   <= rsp_rms_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sample_count = rsp_count_ff;
   assign rsp_if.minimum      = rsp_min_ff;
   assign rsp_if.maximum      = rsp_max_ff;
   assign rsp_if.mean         = rsp_mean_ff;
   assign rsp_if.rms          = rsp_rms_ff;
   assign rsp_if.count_full   = rsp_full_ff;

   // divider remainder always below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_MEAN || state_ff == ST_DIV_SQ) |-> rem_ff < UW'(count_ff))
      else $error("divider remainder not below count");

   // root remainder bounded by twice the partial root
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROOT |-> rem_ff <= UW'({root_ff, 1'b0}))
      else $error("square root remainder out of range");

   // min never above max once a sample is held
   assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> min_ff <= max_ff)
      else $error("running min above running max");

   // an add step raises the count by exactly one unless saturated
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM && count_ff != COUNT_MAX) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("count did not advance on add");

   // a clear word empties the statistics
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_if.opcode == OP_CLEAR) |=> (count_ff == '0 && sum_ff == '0 && sqsum_ff == '0))
      else $error("clear did not empty statistics");

endmodule
